// ===== design/b64_pkg.sv =====
`timescale 1ns / 1ps

package b64_pkg;

  localparam int B64_QUEUE_DEPTH = 2;
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       msg_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       msg_end;
  } out_item_t;

  // One finished group: result bytes in order, index of the last one.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            msg_last;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] s8;
    s8 = {2'b00, s};
    if (s < 6'd26) begin
      return s8 + 8'h41;
    end else if (s < 6'd52) begin
      return s8 - 8'd26 + 8'h61;
    end else if (s < 6'd62) begin
      return s8 - 8'd52 + 8'h30;
    end else if (s == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

  function automatic logic [5:0] sextet_of(input logic [7:0] ch);
    logic [7:0] v;
    v = 8'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      v = ch - 8'h41;
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      v = ch - 8'h61 + 8'd26;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      v = ch - 8'h30 + 8'd52;
    end else if (ch == 8'h2B) begin
      v = 8'd62;
    end else if (ch == 8'h2F) begin
      v = 8'd63;
    end
    return v[5:0];
  endfunction

endpackage

// ===== design/b64_stream_if.sv =====
`timescale 1ns / 1ps

interface b64_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/b64_front.sv =====
`timescale 1ns / 1ps

module b64_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  b64_stream_if.sink         in_i,
  input  b64_pkg::q_status_t q_stat_i,
  output logic               push_o,
  output b64_pkg::grp_t      grp_o
);
  import b64_pkg::*;

  dir_e        dir_q, dir_d;
  logic [23:0] buf_q, buf_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  pad_q, pad_d;

  logic        accept;
  logic [7:0]  ch;
  logic        last;
  logic [1:0]  cnt_inc;
  logic [23:0] enc_buf;
  logic        enc_emit;
  logic        is_pad;
  logic [5:0]  sext;
  logic [1:0]  pad_n;
  logic [23:0] dec_buf;
  logic        dec_emit;
  logic        emit;
  logic [7:0]  db0, db1, db2;

  assign in_i.ready = ~q_stat_i.full;
  assign accept     = in_i.valid & in_i.ready;
  assign ch         = in_i.data.data_byte;
  assign last       = in_i.data.msg_last;
  assign cnt_inc    = cnt_q + 2'd1;

  always_comb begin
    case (cnt_q)
      2'd0:    enc_buf = buf_q | {ch, 16'b0};
      2'd1:    enc_buf = buf_q | {8'b0, ch, 8'b0};
      default: enc_buf = buf_q | {16'b0, ch};
    endcase
  end

  assign enc_emit = (cnt_inc == 2'd3) | last;

  assign is_pad = (cnt_q >= 2'd2) && (ch == PAD_CHAR);
  assign sext   = is_pad ? 6'd63 : sextet_of(ch);

  always_comb begin
    pad_n = pad_q;
    if (is_pad) begin
      pad_n = pad_q | ((cnt_q == 2'd2) ? 2'b01 : 2'b10);
    end
  end

  always_comb begin
    case (cnt_q)
      2'd0:    dec_buf = buf_q | {sext, 18'b0};
      2'd1:    dec_buf = buf_q | {6'b0, sext, 12'b0};
      2'd2:    dec_buf = buf_q | {12'b0, sext, 6'b0};
      default: dec_buf = buf_q | {18'b0, sext};
    endcase
  end

  assign dec_emit = (cnt_q == 2'd3);
  assign db0      = {dec_buf[23:18], dec_buf[17:16]};
  assign db1      = {dec_buf[15:12], dec_buf[11:8]};
  assign db2      = {dec_buf[7:6], dec_buf[5:0]};

  assign emit   = (dir_q == DIR_DECODE) ? dec_emit : enc_emit;
  assign push_o = accept & emit;

  always_comb begin
    grp_o.msg_last = last;
    if (dir_q == DIR_DECODE) begin
      grp_o.bytes[0] = db0;
      grp_o.bytes[1] = pad_n[0] ? db2 : db1;
      grp_o.bytes[2] = db2;
      grp_o.bytes[3] = db2;
      grp_o.last_idx = {1'b0, ~pad_n[0]} + {1'b0, ~pad_n[1]};
    end else begin
      grp_o.bytes[0] = enc_char(enc_buf[23:18]);
      grp_o.bytes[1] = enc_char(enc_buf[17:12]);
      grp_o.bytes[2] = (cnt_inc >= 2'd2) ? enc_char(enc_buf[11:6]) : PAD_CHAR;
      grp_o.bytes[3] = (cnt_inc == 2'd3) ? enc_char(enc_buf[5:0]) : PAD_CHAR;
      grp_o.last_idx = 2'd3;
    end
  end

  always_comb begin
    dir_d = dir_q;
    buf_d = buf_q;
    cnt_d = cnt_q;
    pad_d = pad_q;
    if (cfg_we_i) begin
      dir_d = dir_e'(cfg_wdata_i);
      buf_d = '0;
      cnt_d = '0;
      pad_d = '0;
    end else if (accept) begin
      if (emit || last) begin
        buf_d = '0;
        cnt_d = '0;
        pad_d = '0;
      end else if (dir_q == DIR_DECODE) begin
        buf_d = dec_buf;
        cnt_d = cnt_inc;
        pad_d = pad_n;
      end else begin
        buf_d = enc_buf;
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_ENCODE;
      buf_q <= '0;
      cnt_q <= '0;
      pad_q <= '0;
    end else begin
      dir_q <= dir_d;
      buf_q <= buf_d;
      cnt_q <= cnt_d;
      pad_q <= pad_d;
    end
  end

endmodule

// ===== design/b64_queue.sv =====
`timescale 1ns / 1ps

module b64_queue #(
  parameter int Depth = b64_pkg::B64_QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  b64_pkg::grp_t      grp_i,
  input  logic               pop_i,
  output b64_pkg::grp_t      grp_o,
  output b64_pkg::q_status_t q_stat_o
);
  import b64_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  grp_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign q_stat_o.full  = (cnt_q == CntW'(Depth));
  assign q_stat_o.empty = (cnt_q == '0);
  assign grp_o          = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== design/b64_back.sv =====
`timescale 1ns / 1ps

module b64_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b64_pkg::grp_t      grp_i,
  input  b64_pkg::q_status_t q_stat_i,
  output logic               pop_o,
  b64_stream_if.source       out_o
);
  import b64_pkg::*;

  logic       busy_q, busy_d;
  grp_t       cur_q, cur_d;
  logic [1:0] idx_q, idx_d;
  logic       taken;
  logic       at_end;
  logic       done;

  assign at_end = (idx_q == cur_q.last_idx);
  assign taken  = out_o.valid & out_o.ready;
  assign done   = taken & at_end;
  assign pop_o  = ~q_stat_i.empty & (~busy_q | done);

  assign out_o.valid         = busy_q;
  assign out_o.data.out_byte = cur_q.bytes[idx_q];
  assign out_o.data.run_end  = at_end;
  assign out_o.data.msg_end  = at_end & cur_q.msg_last;

  always_comb begin
    busy_d = busy_q;
    cur_d  = cur_q;
    idx_d  = idx_q;
    if (pop_o) begin
      cur_d  = grp_i;
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (taken) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

endmodule

// ===== design/base64_codec.sv =====
`timescale 1ns / 1ps

// Streaming base64 codec, alphabet A-Z a-z 0-9 + / with '=' padding.
// cfg_wdata_i selects the direction (0 encode, 1 decode); a write clears any
// partial group and must happen only while the codec is idle. The input side
// takes one request per cycle while the group queue has room; the output
// serializer sends one result per cycle while out_o is ready, so encoding
// is bound by the output at 4 characters per 3-byte group and decoding
// sustains one character per cycle. The request that completes a group is
// registered into the group queue, then into the output register that shows
// its first result. A partial decode group at message end gives no result.
module base64_codec #(
  parameter int QueueDepth = b64_pkg::B64_QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  b64_stream_if.sink   in_i,
  b64_stream_if.source out_o
);
  import b64_pkg::*;

  grp_t      push_grp;
  grp_t      head_grp;
  q_status_t q_stat;
  logic      push;
  logic      pop;

  b64_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .grp_o       (push_grp)
  );

  b64_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .grp_i    (push_grp),
    .pop_i    (pop),
    .grp_o    (head_grp),
    .q_stat_o (q_stat)
  );

  b64_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .grp_i    (head_grp),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("group pushed into full queue");

  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("group popped from empty queue");

  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.data.run_end && q_stat.empty)
      |=> !out_o.valid)
    else $error("result shown with no group pending");

endmodule
